>>> hw/rtl/cs0u_pkg.sv
package cs0u_pkg;

  localparam logic [7:0] COMP_ID_8   = 8'd8;
  localparam logic [7:0] COMP_ID_16  = 8'd16;
  localparam logic [7:0] COMP_ID_RST = COMP_ID_8;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BAD_ID = 2'd1;
  localparam logic [1:0] STATUS_TRUNC  = 2'd2;

  localparam logic [15:0] UTF8_LIM_1B = 16'h0080;
  localparam logic [15:0] UTF8_LIM_2B = 16'h0800;
  localparam logic [2:0]  UTF8_LEAD_2 = 3'b110;
  localparam logic [3:0]  UTF8_LEAD_3 = 4'b1110;
  localparam logic [1:0]  UTF8_CONT   = 2'b10;

  localparam logic [1:0] CNT_1 = 2'd1;
  localparam logic [1:0] CNT_2 = 2'd2;
  localparam logic [1:0] CNT_3 = 2'd3;

  // converter state carried between requests
  typedef struct packed {
    logic       half_pending;
    logic [7:0] high_byte;
    logic [7:0] output_count;
    logic       truncated_flag;
  } enc_state_t;

  // all results caused by one request
  typedef struct packed {
    logic [1:0]      cnt;        // number of results, 1..3
    logic [2:0][7:0] bytes;
    logic            has_byte;   // 0 only for the single end-only result
    logic            end_name;   // applies to the final result of the group
    logic [1:0]      status;
    logic [7:0]      base_count; // output count before this group
  } res_group_t;

endpackage

>>> hw/rtl/cs0_to_utf8_converter_core.sv
// Converts an OSTA compressed-Unicode name, one name byte per request, into
// UTF-8 bytes, one per result. cfg_wr_data sets the compression id (8 or 16,
// reset 8; anything else yields only an end result with bad-id status). A
// request that completes a character of n UTF-8 bytes (n = 1..3) is followed
// by n results in order; a request with no result produces none. The output
// register emits one result per cycle while out_ready is high, and sets the
// rate: a request is taken in the same cycle as the final result of the
// previous group, and not before it. The first result of a group is registered
// and appears in the cycle after its request. A name is closed by the request with in_last.
module cs0_to_utf8_converter_core #(
  parameter int NAME_LEN = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_has_data,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_has_byte,
  output logic       out_end_of_name,
  output logic [1:0] out_status,
  output logic [7:0] out_total_length
);

  logic [7:0]           comp_id_r;
  cs0u_pkg::enc_state_t state_r;
  cs0u_pkg::enc_state_t state_nxt;
  cs0u_pkg::res_group_t grp;
  logic                 grp_valid;
  logic                 can_push;
  logic                 in_acc;

  assign in_ready = can_push;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_id_r <= cs0u_pkg::COMP_ID_RST;
    end else if (cfg_wr_en) begin
      comp_id_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  cs0u_encoder #(
    .NAME_LEN (NAME_LEN)
  ) u_encoder (
    .comp_id   (comp_id_r),
    .state_cur (state_r),
    .data_byte (in_data_byte),
    .has_data  (in_has_data),
    .last      (in_last),
    .state_nxt (state_nxt),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  cs0u_serializer u_serializer (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_acc && grp_valid),
    .grp_in       (grp),
    .can_push     (can_push),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_out_byte),
    .has_byte     (out_has_byte),
    .end_of_name  (out_end_of_name),
    .status       (out_status),
    .total_length (out_total_length)
  );

endmodule

>>> hw/rtl/cs0u_encoder.sv
module cs0u_encoder #(
  parameter int NAME_LEN = 255
) (
  input  logic [7:0]           comp_id,
  input  cs0u_pkg::enc_state_t state_cur,
  input  logic [7:0]           data_byte,
  input  logic                 has_data,
  input  logic                 last,
  output cs0u_pkg::enc_state_t state_nxt,
  output logic                 grp_valid,
  output cs0u_pkg::res_group_t grp
);

  localparam logic [7:0] CNT_LIMIT = 8'(NAME_LEN - 3);

  logic        id8;
  logic        id16;
  logic        char_valid;
  logic [15:0] char_code;
  logic        hp_mid;
  logic [7:0]  hb_mid;
  logic        trunc_new;
  logic [1:0]  n_bytes;
  logic [2:0][7:0] enc_bytes;

  assign id8  = (comp_id == cs0u_pkg::COMP_ID_8);
  assign id16 = (comp_id == cs0u_pkg::COMP_ID_16);

  // assemble the character code
  always_comb begin
    char_valid = 1'b0;
    char_code  = 16'h0000;
    hp_mid     = 1'b0;
    hb_mid     = 8'h00;
    if (id8) begin
      char_valid = has_data;
      char_code  = {8'h00, data_byte};
    end else if (id16) begin
      hp_mid = state_cur.half_pending;
      hb_mid = state_cur.high_byte;
      if (has_data) begin
        if (state_cur.half_pending) begin
          char_valid = 1'b1;
          char_code  = {state_cur.high_byte, data_byte};
          hp_mid     = 1'b0;
          hb_mid     = 8'h00;
        end else begin
          hp_mid = 1'b1;
          hb_mid = data_byte;
        end
      end
      // odd trailing byte pairs with a zero low byte
      if (last && hp_mid) begin
        char_valid = 1'b1;
        char_code  = {hb_mid, 8'h00};
        hp_mid     = 1'b0;
        hb_mid     = 8'h00;
      end
    end
  end

  // UTF-8 encode
  always_comb begin
    trunc_new = state_cur.truncated_flag;
    n_bytes   = 2'd0;
    enc_bytes = '0;
    if (char_valid) begin
      if (state_cur.output_count > CNT_LIMIT) begin
        trunc_new = 1'b1;
      end else if (char_code < cs0u_pkg::UTF8_LIM_1B) begin
        n_bytes      = cs0u_pkg::CNT_1;
        enc_bytes[0] = char_code[7:0];
      end else if (char_code < cs0u_pkg::UTF8_LIM_2B) begin
        n_bytes      = cs0u_pkg::CNT_2;
        enc_bytes[0] = {cs0u_pkg::UTF8_LEAD_2, char_code[10:6]};
        enc_bytes[1] = {cs0u_pkg::UTF8_CONT, char_code[5:0]};
      end else begin
        n_bytes      = cs0u_pkg::CNT_3;
        enc_bytes[0] = {cs0u_pkg::UTF8_LEAD_3, char_code[15:12]};
        enc_bytes[1] = {cs0u_pkg::UTF8_CONT, char_code[11:6]};
        enc_bytes[2] = {cs0u_pkg::UTF8_CONT, char_code[5:0]};
      end
    end
  end

  always_comb begin
    grp_valid = 1'b0;
    grp       = '0;
    state_nxt = state_cur;
    if (!id8 && !id16) begin
      if (last) begin
        grp_valid     = 1'b1;
        grp.cnt       = cs0u_pkg::CNT_1;
        grp.has_byte  = 1'b0;
        grp.end_name  = 1'b1;
        grp.status    = cs0u_pkg::STATUS_BAD_ID;
        grp.base_count = 8'h00;
        state_nxt     = '0;
      end
    end else begin
      state_nxt.half_pending   = hp_mid;
      state_nxt.high_byte      = hb_mid;
      state_nxt.truncated_flag = trunc_new;
      state_nxt.output_count   = state_cur.output_count + {6'd0, n_bytes};
      grp.bytes      = enc_bytes;
      grp.end_name   = last;
      grp.status     = trunc_new ? cs0u_pkg::STATUS_TRUNC : cs0u_pkg::STATUS_OK;
      grp.base_count = state_cur.output_count;
      if (n_bytes != 2'd0) begin
        grp_valid    = 1'b1;
        grp.cnt      = n_bytes;
        grp.has_byte = 1'b1;
      end else if (last) begin
        grp_valid    = 1'b1;
        grp.cnt      = cs0u_pkg::CNT_1;
        grp.has_byte = 1'b0;
      end
      if (last) begin
        state_nxt = '0;
      end
    end
  end

endmodule

>>> hw/rtl/cs0u_serializer.sv
module cs0u_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cs0u_pkg::res_group_t grp_in,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 has_byte,
  output logic                 end_of_name,
  output logic [1:0]           status,
  output logic [7:0]           total_length
);

  cs0u_pkg::res_group_t grp_r;
  logic                 busy_r;
  logic [1:0]           idx_r;
  logic                 at_last;
  logic                 take;

  assign at_last  = (idx_r == grp_r.cnt - 2'd1);
  assign take     = busy_r && out_ready;
  assign can_push = !busy_r || (out_ready && at_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (push) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (take) begin
      if (at_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      grp_r <= grp_in;
    end
  end

  assign out_valid    = busy_r;
  assign out_byte     = grp_r.has_byte ? grp_r.bytes[idx_r] : 8'h00;
  assign has_byte     = grp_r.has_byte;
  assign end_of_name  = grp_r.end_name && at_last;
  assign status       = grp_r.status;
  assign total_length = grp_r.has_byte ? (grp_r.base_count + {6'd0, idx_r} + 8'd1)
                                       : grp_r.base_count;

endmodule

>>> verif/tb_cs0_to_utf8_converter_core.sv
`timescale 1ns / 100ps

module tb_cs0_to_utf8_converter_core;

  localparam int NAME_LEN       = 255;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_byte;
    logic       end_name;
    logic [1:0] status;
    logic [7:0] total;
  } utf8_res_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_has_data;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_out_byte;
  logic       out_has_byte;
  logic       out_end_of_name;
  logic [1:0] out_status;
  logic [7:0] out_total_length;

  // predictor state and expected UTF-8 stream
  logic [7:0]           comp_id = cs0u_pkg::COMP_ID_RST;
  cs0u_pkg::enc_state_t st      = '0;
  utf8_res_t            utf8_q[$];

  int   mismatches  = 0;
  int   n_sent      = 0;
  int   idle_cycles = 0;
  logic idle_en     = 1'b1;
  logic hold_req    = 1'b0;

  cs0_to_utf8_converter_core #(
    .NAME_LEN(NAME_LEN)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_has_data     (in_has_data),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_byte    (out_out_byte),
    .out_has_byte    (out_has_byte),
    .out_end_of_name (out_end_of_name),
    .out_status      (out_status),
    .out_total_length(out_total_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int utf8_encode(input logic [15:0] c, output logic [2:0][7:0] enc);
    enc = '0;
    if (int'(st.output_count) > NAME_LEN - 3) begin
      st.truncated_flag = 1'b1;
      return 0;
    end
    if (c < cs0u_pkg::UTF8_LIM_1B) begin
      enc[0] = c[7:0];
      return 1;
    end
    if (c < cs0u_pkg::UTF8_LIM_2B) begin
      enc[0] = {cs0u_pkg::UTF8_LEAD_2, c[10:6]};
      enc[1] = {cs0u_pkg::UTF8_CONT, c[5:0]};
      return 2;
    end
    enc[0] = {cs0u_pkg::UTF8_LEAD_3, c[15:12]};
    enc[1] = {cs0u_pkg::UTF8_CONT, c[11:6]};
    enc[2] = {cs0u_pkg::UTF8_CONT, c[5:0]};
    return 3;
  endfunction

  task automatic push_result(input logic [7:0] ch, input logic hb, input logic en,
                             input logic [1:0] stat, input logic [7:0] total);
    utf8_res_t r;
    r = '{ch: ch, has_byte: hb, end_name: en, status: stat, total: total};
    utf8_q.push_back(r);
  endtask

  task automatic convert_request(input logic [7:0] b, input logic hd, input logic lst);
    logic [2:0][7:0] enc;
    logic [1:0]      stat;
    int              n;
    enc = '0;
    n   = 0;
    if (comp_id != cs0u_pkg::COMP_ID_8 && comp_id != cs0u_pkg::COMP_ID_16) begin
      if (lst) begin
        push_result(8'h00, 1'b0, 1'b1, cs0u_pkg::STATUS_BAD_ID, 8'h00);
        st = '0;
      end
      return;
    end
    if (comp_id == cs0u_pkg::COMP_ID_8) begin
      st.half_pending = 1'b0;
      st.high_byte    = 8'h00;
      if (hd) n = utf8_encode({8'h00, b}, enc);
    end else begin
      if (hd) begin
        if (st.half_pending) begin
          n = utf8_encode({st.high_byte, b}, enc);
          st.half_pending = 1'b0;
          st.high_byte    = 8'h00;
        end else begin
          st.high_byte    = b;
          st.half_pending = 1'b1;
        end
      end
      // odd trailing byte pairs with a zero low byte
      if (lst && st.half_pending) begin
        n = utf8_encode({st.high_byte, 8'h00}, enc);
        st.half_pending = 1'b0;
        st.high_byte    = 8'h00;
      end
    end
    stat = st.truncated_flag ? cs0u_pkg::STATUS_TRUNC : cs0u_pkg::STATUS_OK;
    for (int k = 0; k < n; k++) begin
      st.output_count = st.output_count + 8'd1;
      push_result(enc[k], 1'b1, lst && (k == n - 1), stat, st.output_count);
    end
    if (lst && n == 0) push_result(8'h00, 1'b0, 1'b1, stat, st.output_count);
    if (lst) st = '0;
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_req(input logic [7:0] b, input logic hd, input logic lst);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_has_data  <= hd;
    in_last      <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    convert_request(b, hd, lst);
  endtask

  // block is idle once the expected stream is empty and a settling wait has passed
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (utf8_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_comp_id(input logic [7:0] id);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= id;
    @(posedge clk);
    comp_id = id;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 8'h07));
      1:       return 8'($urandom_range(8'h08, 8'h7f));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_comp_id();
    logic [7:0] id;
    case ($urandom_range(0, 9))
      0: begin
        do id = 8'($urandom_range(0, 255));
        while (id == cs0u_pkg::COMP_ID_8 || id == cs0u_pkg::COMP_ID_16);
      end
      1, 2, 3: id = cs0u_pkg::COMP_ID_16;
      default: id = cs0u_pkg::COMP_ID_8;
    endcase
    return id;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_empty_name();
    send_req(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_mode_8();
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'h7f, 1'b1, 1'b0);
    send_req(8'h80, 1'b1, 1'b0);
    send_req(8'ha5, 1'b0, 1'b0);  // no data, not last: dropped
    send_req(8'hff, 1'b1, 1'b1);
    send_req(8'h41, 1'b1, 1'b0);
    send_req(8'h00, 1'b0, 1'b1);  // end with nothing left to send
  endtask

  task automatic test_mode_16();
    set_comp_id(cs0u_pkg::COMP_ID_16);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'h7f, 1'b1, 1'b0);
    send_req(8'h07, 1'b1, 1'b0);
    send_req(8'hff, 1'b1, 1'b0);
    send_req(8'h08, 1'b1, 1'b0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'hff, 1'b1, 1'b0);
    send_req(8'hff, 1'b1, 1'b0);
    send_req(8'h12, 1'b1, 1'b1);  // odd trailing high byte
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'h00, 1'b0, 1'b1);  // dataless end closes pending half
  endtask

  task automatic test_mode_switch();
    set_comp_id(cs0u_pkg::COMP_ID_16);
    send_req(8'hab, 1'b1, 1'b0);
    set_comp_id(cs0u_pkg::COMP_ID_8);  // pending high byte gets dropped
    send_req(8'h41, 1'b1, 1'b1);
  endtask

  task automatic test_bad_id();
    set_comp_id(8'h00);
    send_req(8'h41, 1'b1, 1'b0);
    send_req(8'h42, 1'b1, 1'b1);
    set_comp_id(8'hff);
    send_req(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_truncation();
    set_comp_id(cs0u_pkg::COMP_ID_8);
    while (int'(st.output_count) <= NAME_LEN - 3)
      send_req(8'($urandom_range(8'h80, 8'hff)), 1'b1, 1'b0);
    repeat (6) send_req(rand_byte(), 1'b1, 1'b0);
    send_req(rand_byte(), 1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    set_comp_id(cs0u_pkg::COMP_ID_8);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_req(8'($urandom_range(8'h80, 8'hff)), 1'b1, i == 39);
    wait_drain();
  endtask

  task automatic test_random_names(input int n_items);
    int stop_at;
    int len;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) set_comp_id(pick_comp_id());
      len = $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        if (i == len - 1) begin
          send_req(rand_byte(), $urandom_range(0, 3) != 0, 1'b1);
        end else if ($urandom_range(0, 11) == 0) begin
          send_req(rand_byte(), 1'b0, 1'b0);
        end else begin
          if ($urandom_range(0, 39) == 0) set_comp_id(pick_comp_id());
          send_req(rand_byte(), 1'b1, 1'b0);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 8'h00;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_has_data  <= 1'b0;
    in_last      <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_name();
    test_mode_8();
    test_mode_16();
    test_mode_switch();
    test_bad_id();
    test_truncation();
    test_backpressure();
    test_random_names(150);
    idle_en = 1'b0;
    test_random_names(30);

    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && utf8_q.size() == 0) begin
      $display("tb_cs0_to_utf8_converter_core: done, clean");
    end else begin
      $display("tb_cs0_to_utf8_converter_core: done, errors");
    end
    $finish;
  end

  // result side ready, with random stalls and one long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    utf8_res_t got;
    utf8_res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{ch: out_out_byte, has_byte: out_has_byte, end_name: out_end_of_name,
              status: out_status, total: out_total_length};
      if (utf8_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: byte=%h has=%b end=%b status=%0d total=%0d",
                   got.ch, got.has_byte, got.end_name, got.status, got.total);
      end else begin
        want = utf8_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: exp byte=%h has=%b end=%b status=%0d total=%0d,",
                      " got byte=%h has=%b end=%b status=%0d total=%0d"},
                     want.ch, want.has_byte, want.end_name, want.status, want.total,
                     got.ch, got.has_byte, got.end_name, got.status, got.total);
        end
      end
    end
  end

  // watchdog: cycles with no request moving on either channel
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_cs0_to_utf8_converter_core: done, errors");
        $finish;
      end
    end
  end

endmodule
